// ===== src/bba_pkg.sv =====
// Buddy block allocator package: sizing constants, status codes, FSM states
// and the control/status structs between controller and datapath.
// No dependencies.
package bba_pkg;

   localparam int POOL_ORDER   = 16;
   localparam int MIN_ORDER    = 5;
   localparam int HEADER_BYTES = 4;

   localparam int LEVELS  = POOL_ORDER - MIN_ORDER + 1;
   localparam int LEAF_W  = LEVELS - 1;
   localparam int NODE_W  = LEVELS;
   localparam int DEPTH_W = $clog2(LEVELS);
   localparam int K_W     = $clog2(POOL_ORDER + 2);
   localparam int PAIR_W  = 2 * LEVELS;
   localparam int TBL_W   = DEPTH_W + 1;
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 17;
   localparam int STAT_W  = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_TOO_BIG  = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_DESC,
      S_SPLIT,
      S_ASC,
      S_ROOT,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic decode;
      logic lookup;
      logic desc;
      logic split;
      logic asc;
      logic root;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic clr_done;
      logic is_free;
      logic fail;
      logic alloc_desc;
      logic free_root;
      logic t_zero;
      logic desc_last;
      logic asc_last;
      logic out_free;
   } sts_type;

endpackage

// ===== src/buddy_block_allocator.sv =====
// Buddy block allocator top level: controller plus datapath.
// One word is worked on at a time: the next word is taken once the result is
// issued, later if the result register is still held; the mask-tree port sets one level per cycle.
// Synchronous reset starts a clearing pass of 2048 entries; no word is taken then.
// Depends on bba_pkg, bba_ctrl, bba_dpath.
module buddy_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bba_pkg::ADDR_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [bba_pkg::SIZE_W-1:0]  req_size,
   input  logic [bba_pkg::ADDR_W-1:0]  req_free_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bba_pkg::STAT_W-1:0]  rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_addr,
   output logic [bba_pkg::SIZE_W-1:0]  rsp_block_bytes
);

   bba_pkg::ctl_type ctl;
   bba_pkg::sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bba_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_size        (req_size),
      .req_free_addr   (req_free_addr),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_addr        (rsp_addr),
      .rsp_block_bytes (rsp_block_bytes)
   );

endmodule

// ===== src/bba_ctrl.sv =====
// Buddy block allocator controller: sequences clear, decode, tree descent,
// split and merge ascent. Depends on bba_pkg.
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::sts_type sts,
   output bba_pkg::ctl_type ctl
);

   bba_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (sts.clr_done) state_in = bba_pkg::S_IDLE;
         end
         bba_pkg::S_IDLE: begin
            if (req_valid) state_in = bba_pkg::S_DECODE;
         end
         bba_pkg::S_DECODE: state_in = bba_pkg::S_LOOKUP;
         bba_pkg::S_LOOKUP: begin
            if (sts.fail) state_in = bba_pkg::S_DONE;
            else if (!sts.is_free)
               state_in = sts.alloc_desc ? bba_pkg::S_DESC : bba_pkg::S_SPLIT;
            else
               state_in = sts.free_root ? bba_pkg::S_ROOT : bba_pkg::S_ASC;
         end
         bba_pkg::S_DESC: begin
            if (sts.desc_last) state_in = bba_pkg::S_SPLIT;
         end
         bba_pkg::S_SPLIT: begin
            state_in = sts.t_zero ? bba_pkg::S_ROOT : bba_pkg::S_ASC;
         end
         bba_pkg::S_ASC: begin
            if (sts.asc_last) state_in = bba_pkg::S_ROOT;
         end
         bba_pkg::S_ROOT: state_in = bba_pkg::S_DONE;
         bba_pkg::S_DONE: begin
            if (sts.out_free) state_in = bba_pkg::S_IDLE;
         end
         default: state_in = bba_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bba_pkg::S_CLEAR:  ctl.clear = 1'b1;
         bba_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         bba_pkg::S_DECODE: ctl.decode = 1'b1;
         bba_pkg::S_LOOKUP: ctl.lookup = 1'b1;
         bba_pkg::S_DESC:   ctl.desc   = 1'b1;
         bba_pkg::S_SPLIT:  ctl.split  = 1'b1;
         bba_pkg::S_ASC:    ctl.asc    = 1'b1;
         bba_pkg::S_ROOT:   ctl.root   = 1'b1;
         bba_pkg::S_DONE:   ctl.finish = sts.out_free;
         default: ctl = '0;
      endcase
   end

endmodule

// ===== src/bba_dpath.sv =====
// Buddy block allocator datapath: availability-mask tree memory, allocation
// table, size/offset arithmetic and the result register. Depends on bba_pkg.
module bba_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  bba_pkg::ctl_type                ctl,
   output bba_pkg::sts_type                sts,
   input  logic                            csr_we,
   input  logic [bba_pkg::ADDR_W-1:0]      csr_wdata,
   input  logic                            req_cmd,
   input  logic [bba_pkg::SIZE_W-1:0]      req_size,
   input  logic [bba_pkg::ADDR_W-1:0]      req_free_addr,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [bba_pkg::STAT_W-1:0]      rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]      rsp_addr,
   output logic [bba_pkg::SIZE_W-1:0]      rsp_block_bytes
);

   localparam int L  = bba_pkg::LEVELS;
   localparam int LW = bba_pkg::LEAF_W;
   localparam int NW = bba_pkg::NODE_W;
   localparam int DW = bba_pkg::DEPTH_W;

   // pair entry at parent p: {mask of 2p+1, mask of 2p}; mask bit j = free node at depth j
   logic [bba_pkg::PAIR_W-1:0] pair_mem [2**LW];
   logic [bba_pkg::TBL_W-1:0]  tbl_mem  [2**LW];

   logic [bba_pkg::ADDR_W-1:0] base_ff;
   logic                       cmd_ff;
   logic [bba_pkg::SIZE_W-1:0] size_ff;
   logic [bba_pkg::ADDR_W-1:0] faddr_ff;
   logic                       big_ff, badfree_ff, merge_ff;
   logic [DW-1:0]              t_ff, d_ff, lvl_ff;
   logic [NW-1:0]              node_ff;
   logic [L-1:0]               contrib_ff, root_ff;
   logic [LW-1:0]              leaf_ff;
   logic [LW:0]                clr_ff;
   bba_pkg::status_type        stat_ff;
   logic [bba_pkg::PAIR_W-1:0] pair_rd_ff;
   logic [bba_pkg::TBL_W-1:0]  tbl_rd_ff;
   logic                       rsp_valid_ff;
   logic [bba_pkg::STAT_W-1:0] rsp_status_ff;
   logic [bba_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [bba_pkg::SIZE_W-1:0] rsp_bytes_ff;

   logic [bba_pkg::ADDR_W-1:0] need, off_calc;
   logic [bba_pkg::K_W-1:0]    k_calc, k_out;
   logic                       big_calc, bad_calc;
   logic [DW-1:0]              t_calc, d_calc, tbl_t, sh_free, sh_split;
   logic [LW-1:0]              li_calc, leaf_t;
   logic [L-1:0]               avail;
   logic                       tbl_live, fail;
   logic [NW-1:0]              fnode, node_down, node_t, node_sh;
   logic                       go_right;
   logic [L-1:0]               left_m, old_c, sib, bitj, m_c, sib_n;
   logic                       own, merge_n, own_r;
   logic [LW-1:0]              rd_addr, tbl_raddr, tbl_waddr, pair_waddr;
   logic                       tbl_we, pair_we;
   logic [bba_pkg::TBL_W-1:0]  tbl_wdata;
   logic [bba_pkg::PAIR_W-1:0] pair_wdata;
   logic                       ok;

   // size and offset decode
   always_comb begin
      need     = bba_pkg::ADDR_W'(size_ff) + bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
      k_calc   = bba_pkg::K_W'(bba_pkg::MIN_ORDER);
      for (int i = bba_pkg::MIN_ORDER; i <= bba_pkg::POOL_ORDER; i++) begin
         if (need > (32'd1 << i)) k_calc = bba_pkg::K_W'(i + 1);
      end
      big_calc = need > (32'd1 << bba_pkg::POOL_ORDER);
      t_calc   = DW'(bba_pkg::K_W'(bba_pkg::POOL_ORDER) - k_calc);
      off_calc = faddr_ff - base_ff - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
      bad_calc = ((off_calc >> bba_pkg::POOL_ORDER) != '0) ||
                 (off_calc[bba_pkg::MIN_ORDER-1:0] != '0);
      li_calc  = off_calc[bba_pkg::POOL_ORDER-1:bba_pkg::MIN_ORDER];
   end

   // lookup: deepest depth at or above t with a free block; on free, the table entry gives the node
   always_comb begin
      for (int i = 0; i < L; i++) begin
         avail[i] = root_ff[i] && (DW'(i) <= t_ff);
      end
      d_calc = '0;
      for (int i = 0; i < L; i++) begin
         if (avail[i]) d_calc = DW'(i);
      end
      tbl_live = tbl_rd_ff[bba_pkg::TBL_W-1];
      tbl_t    = tbl_rd_ff[DW-1:0];
      sh_free  = DW'(LW) - tbl_t;
      fnode    = (NW'(1) << tbl_t) | NW'(leaf_ff >> sh_free);
      fail     = cmd_ff ? (badfree_ff || !tbl_live) : (big_ff || (avail == '0));
   end

   // descent and split
   always_comb begin
      left_m    = pair_rd_ff[L-1:0];
      go_right  = !left_m[d_ff];
      node_down = {node_ff[NW-2:0], go_right};
      node_t    = node_ff << (t_ff - d_ff);
      sh_split  = DW'(LW) - t_ff;
      node_sh   = node_t << sh_split;
      leaf_t    = node_sh[LW-1:0];
   end

   // ascent: rebuild masks on the path, merge buddies on free
   always_comb begin
      old_c   = node_ff[0] ? pair_rd_ff[2*L-1:L] : pair_rd_ff[L-1:0];
      sib     = node_ff[0] ? pair_rd_ff[L-1:0] : pair_rd_ff[2*L-1:L];
      bitj    = L'(1) << lvl_ff;
      own     = 1'b0;
      merge_n = 1'b0;
      m_c     = contrib_ff;
      sib_n   = sib;
      if (cmd_ff == bba_pkg::CMD_ALLOC) begin
         own   = (lvl_ff >= d_ff) ? 1'b0 : old_c[lvl_ff];
         sib_n = (lvl_ff > d_ff) ? bitj : sib;
         m_c   = contrib_ff | (own ? bitj : '0);
      end else if (merge_ff && sib[lvl_ff]) begin
         merge_n = 1'b1;
         sib_n   = sib & ~bitj;
      end else begin
         own = merge_ff | old_c[lvl_ff];
         m_c = contrib_ff | (own ? bitj : '0);
      end
      if (cmd_ff == bba_pkg::CMD_ALLOC) own_r = (d_ff == '0) ? 1'b0 : root_ff[0];
      else                              own_r = merge_ff | root_ff[0];
   end

   // memory port selection
   always_comb begin
      rd_addr = LW'(1);
      if (ctl.lookup && cmd_ff)  rd_addr = LW'(fnode >> 1);
      else if (ctl.desc)         rd_addr = LW'(node_down);
      else if (ctl.split)        rd_addr = LW'(node_t >> 1);
      else if (ctl.asc)          rd_addr = LW'(node_ff >> 2);

      tbl_raddr = li_calc;

      pair_we    = ctl.clear || ctl.asc;
      pair_waddr = ctl.clear ? clr_ff[LW-1:0] : LW'(node_ff >> 1);
      pair_wdata = ctl.clear ? '0 : (node_ff[0] ? {m_c, sib_n} : {sib_n, m_c});

      tbl_we    = ctl.clear || ctl.split || (ctl.lookup && cmd_ff && !fail);
      tbl_waddr = leaf_ff;
      tbl_wdata = '0;
      if (ctl.clear) begin
         tbl_waddr = clr_ff[LW-1:0];
      end else if (ctl.split) begin
         tbl_waddr = leaf_t;
         tbl_wdata = {1'b1, t_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
      pair_rd_ff <= pair_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         clr_ff       <= '0;
         root_ff      <= L'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) base_ff <= csr_wdata;
         if (ctl.clear && !clr_ff[LW]) clr_ff <= clr_ff + 1'b1;
         if (ctl.root) root_ff <= contrib_ff | L'(own_r);
         if (ctl.finish)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_cmd;
         size_ff  <= req_size;
         faddr_ff <= req_free_addr;
      end
      if (ctl.decode) begin
         t_ff       <= t_calc;
         big_ff     <= big_calc;
         leaf_ff    <= li_calc;
         badfree_ff <= bad_calc;
      end
      if (ctl.lookup) begin
         if (!fail)       stat_ff <= bba_pkg::ST_OK;
         else if (cmd_ff) stat_ff <= bba_pkg::ST_BAD_FREE;
         else if (big_ff) stat_ff <= bba_pkg::ST_TOO_BIG;
         else             stat_ff <= bba_pkg::ST_NO_BLOCK;
         contrib_ff <= '0;
         if (cmd_ff) begin
            t_ff     <= tbl_t;
            node_ff  <= fnode;
            lvl_ff   <= tbl_t;
            merge_ff <= 1'b1;
         end else begin
            d_ff     <= d_calc;
            node_ff  <= NW'(1);
            lvl_ff   <= '0;
         end
      end
      if (ctl.desc) begin
         node_ff <= node_down;
         lvl_ff  <= lvl_ff + 1'b1;
      end
      if (ctl.split) begin
         node_ff    <= node_t;
         lvl_ff     <= t_ff;
         contrib_ff <= '0;
         merge_ff   <= 1'b0;
         leaf_ff    <= leaf_t;
      end
      if (ctl.asc) begin
         node_ff    <= node_ff >> 1;
         lvl_ff     <= lvl_ff - 1'b1;
         contrib_ff <= m_c | sib_n;
         merge_ff   <= merge_n;
      end
      if (ctl.finish) begin
         rsp_status_ff <= stat_ff;
         rsp_addr_ff   <= (ok && cmd_ff == bba_pkg::CMD_ALLOC) ?
                          base_ff + (bba_pkg::ADDR_W'(leaf_ff) << bba_pkg::MIN_ORDER) +
                          bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES) : '0;
         rsp_bytes_ff  <= ok ? (bba_pkg::SIZE_W'(1) << k_out) : '0;
      end
   end

   assign ok    = (stat_ff == bba_pkg::ST_OK);
   assign k_out = bba_pkg::K_W'(bba_pkg::POOL_ORDER) - bba_pkg::K_W'(t_ff);

   always_comb begin
      sts.clr_done   = clr_ff[LW];
      sts.is_free    = cmd_ff;
      sts.fail       = fail;
      sts.alloc_desc = (d_calc != '0);
      sts.free_root  = (tbl_t == '0);
      sts.t_zero     = (t_ff == '0);
      sts.desc_last  = (DW'(lvl_ff + 1'b1) == d_ff);
      sts.asc_last   = (lvl_ff == DW'(1));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_addr        = rsp_addr_ff;
   assign rsp_block_bytes = rsp_bytes_ff;

endmodule

// ===== src/bba_checker.sv =====
// Buddy block allocator port checker, bound to the top level.
// Depends on bba_pkg.
module bba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bba_pkg::STAT_W-1:0]  rsp_status,
   input logic [bba_pkg::ADDR_W-1:0]  rsp_addr,
   input logic [bba_pkg::SIZE_W-1:0]  rsp_block_bytes
);

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bba_pkg::ST_OK |-> rsp_addr == '0 && rsp_block_bytes == '0)
      else $error("error word carries address or size");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bba_pkg::ST_OK |-> rsp_block_bytes != '0)
      else $error("ok word without block size");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
      else $error("stalled result word changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

// ===== tb/tb_top.sv =====
// Regression bench for buddy_block_allocator: drives allocate/free words, predicts
// each response with an internal buddy-tree model and compares field by field.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 100ps

class alloc_scoreboard;
   typedef struct {
      bba_pkg::status_type status;
      logic [31:0]         addr;
      logic [16:0]         bytes;
   } rsp_word_type;

   bit           node_free [1:4095];
   bit           leaf_live [0:2047];
   logic [3:0]   leaf_depth [0:2047];
   logic [31:0]  pool_base;
   rsp_word_type pending[$];
   logic [31:0]  granted[$];
   int           errors;

   function new();
      foreach (node_free[i]) node_free[i] = 0;
      foreach (leaf_live[i]) leaf_live[i] = 0;
      node_free[1] = 1;
      pool_base = 0;
      errors = 0;
   endfunction

   function void note(logic cmd, logic [16:0] sz, logic [31:0] fa);
      rsp_word_type w;
      int           k, t, d, idx, found;
      logic [31:0]  off;
      w.status = bba_pkg::ST_OK;
      w.addr = 0;
      w.bytes = 0;
      if (cmd == bba_pkg::CMD_ALLOC) begin
         k = 5;
         while (k <= 16 && (64'd1 << k) < (64'(sz) + 4)) k++;
         if (k > 16) begin
            w.status = bba_pkg::ST_TOO_BIG;
         end else begin
            t = 16 - k;
            found = 0;
            for (d = t; d >= 0 && !found; d--) begin
               for (int n = 1 << d; n < (2 << d); n++) begin
                  if (node_free[n]) begin
                     idx = n;
                     found = 1;
                     break;
                  end
               end
               if (found) break;
            end
            if (!found) begin
               w.status = bba_pkg::ST_NO_BLOCK;
            end else begin
               node_free[idx] = 0;
               while (d < t) begin
                  node_free[2*idx+1] = 1;
                  idx = 2 * idx;
                  d++;
               end
               off = (idx - (1 << t)) << k;
               leaf_live[off >> 5] = 1;
               leaf_depth[off >> 5] = t;
               w.addr = pool_base + off + 4;
               w.bytes = 17'(1 << k);
               granted.push_back(w.addr);
            end
         end
      end else begin
         off = fa - pool_base - 4;
         if (off >= 32'h10000 || off[4:0] != 0 || !leaf_live[off >> 5]) begin
            w.status = bba_pkg::ST_BAD_FREE;
         end else begin
            t = leaf_depth[off >> 5];
            k = 16 - t;
            leaf_live[off >> 5] = 0;
            idx = (1 << t) + (off >> k);
            node_free[idx] = 1;
            while (idx > 1 && node_free[idx ^ 1]) begin
               node_free[idx] = 0;
               node_free[idx ^ 1] = 0;
               idx = idx >> 1;
               node_free[idx] = 1;
            end
            w.bytes = 17'(1 << k);
         end
      end
      pending.push_back(w);
   endfunction

   function void check(logic [1:0] st, logic [31:0] addr, logic [16:0] bytes);
      rsp_word_type w;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response word st=%0d addr=%h", st, addr);
         return;
      end
      w = pending.pop_front();
      if (st !== w.status || addr !== w.addr || bytes !== w.bytes) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp st=%0d addr=%h bytes=%0d  got st=%0d addr=%h bytes=%0d",
                     w.status, w.addr, w.bytes, st, addr, bytes);
      end
   endfunction
endclass

module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [31:0] csr_wdata = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_cmd = 0;
   logic [16:0] req_size = 0;
   logic [31:0] req_free_addr = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_addr;
   logic [16:0] rsp_block_bytes;

   alloc_scoreboard sb = new();
   bit calm = 0;
   bit hold_req = 0;
   bit hold_done = 0;
   int stall_left = 0;

   buddy_block_allocator DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_size(req_size), .req_free_addr(req_free_addr),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_addr(rsp_addr), .rsp_block_bytes(rsp_block_bytes)
   );

   always #6 clock = ~clock;

   // response side: random backpressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check(rsp_status, rsp_addr, rsp_block_bytes);
         if (hold_req && !hold_done) begin
            hold_done = 1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 20);
         end
      end
   end

   task automatic send(logic cmd, logic [16:0] sz, logic [31:0] fa);
      if (!calm) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_size <= sz;
      req_free_addr <= fa;
      do @(posedge clock); while (!req_ready);
      sb.note(cmd, sz, fa);
   endtask

   task automatic drain_and_set(logic [31:0] base);
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 0;
      sb.pool_base = base;
   endtask

   task automatic free_all();
      while (sb.granted.size() != 0)
         send(bba_pkg::CMD_FREE, 17'($urandom), sb.granted.pop_front());
   endtask

   task automatic random_phase(int count);
      int          r, i;
      logic [31:0] a;
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3 && n < count / 3 + 60);
         r = $urandom_range(99);
         if (r < 55) begin
            i = $urandom_range(99);
            if (i < 70)
               send(bba_pkg::CMD_ALLOC, 17'($urandom_range(60)), $urandom);
            else if (i < 90)
               send(bba_pkg::CMD_ALLOC, 17'($urandom_range(2000)), $urandom);
            else if (i < 97)
               send(bba_pkg::CMD_ALLOC, 17'($urandom_range(65532)), $urandom);
            else
               send(bba_pkg::CMD_ALLOC, 17'($urandom_range(17'h1FFFF, 65533)), $urandom);
         end else if (r < 92 && sb.granted.size() != 0) begin
            i = $urandom_range(sb.granted.size() - 1);
            a = sb.granted[i];
            sb.granted.delete(i);
            send(bba_pkg::CMD_FREE, 17'($urandom), a);
            if ($urandom_range(9) == 0) send(bba_pkg::CMD_FREE, 17'($urandom), a);
         end else begin
            i = $urandom_range(2);
            if (i == 0)
               send(bba_pkg::CMD_FREE, 17'($urandom), $urandom);
            else if (i == 1)
               send(bba_pkg::CMD_FREE, 17'($urandom), sb.pool_base + 4 +
                    ($urandom_range(2047) << 5) + $urandom_range(31, 1));
            else
               send(bba_pkg::CMD_FREE, 17'($urandom),
                    sb.pool_base + 4 + ($urandom_range(2047) << 5));
         end
      end
      calm = 0;
      free_all();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      drain_and_set(32'h0);

      // directed: whole pool, exhaustion, size bounds, bad frees
      send(bba_pkg::CMD_ALLOC, 17'd65532, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd0, 32'd0);
      send(bba_pkg::CMD_FREE, 17'h1FFFF, 32'd4);
      send(bba_pkg::CMD_FREE, 17'd0, 32'd4);
      send(bba_pkg::CMD_ALLOC, 17'd65533, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'h1FFFF, 32'hFFFF_FFFF);
      send(bba_pkg::CMD_ALLOC, 17'd65536, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd0, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd28, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd29, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd1000, 32'd0);
      send(bba_pkg::CMD_ALLOC, 17'd32764, 32'd0);
      send(bba_pkg::CMD_FREE, 17'd0, 32'd5);
      send(bba_pkg::CMD_FREE, 17'd0, 32'd0);
      send(bba_pkg::CMD_FREE, 17'd0, 32'hFFFF_FFFF);
      send(bba_pkg::CMD_FREE, 17'd0, 32'h0001_0004);
      free_all();

      drain_and_set(32'h0);
      hold_req = 1;
      random_phase(145);
      drain_and_set(32'hFFFF_FFF0);
      random_phase(145);
      drain_and_set(32'h8000_0000);
      random_phase(145);
      drain_and_set($urandom);
      random_phase(145);
      drain_and_set(32'hFFFF_FFFF);
      random_phase(145);

      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("buddy_block_allocator regression: pass");
      end else begin
         $display("buddy_block_allocator regression: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("buddy_block_allocator regression: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/bba_pkg.sv
src/bba_ctrl.sv
src/bba_dpath.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
tb/tb_top.sv
